@@ hw/rtl/tgi_pkg.sv @@
`timescale 1ns / 1ps
package tgi_pkg;

   localparam int CoordW = 32;
   localparam int StepW = 31;
   localparam int CountW = 7;
   localparam int SampleW = 16;
   localparam int IndexW = 18;
   localparam int FracW = 16;
   localparam int CsrAddrW = 5;

   localparam logic [0:0] CMD_WRITE = 1'b0;
   localparam logic [0:0] CMD_QUERY = 1'b1;

   localparam logic [2:0] REG_X_ORIGIN = 3'd0;
   localparam logic [2:0] REG_Y_ORIGIN = 3'd1;
   localparam logic [2:0] REG_Z_ORIGIN = 3'd2;
   localparam logic [2:0] REG_X_STEP = 3'd3;
   localparam logic [2:0] REG_Y_STEP = 3'd4;
   localparam logic [2:0] REG_Z_STEP = 3'd5;
   localparam logic [2:0] REG_X_COUNT = 3'd6;
   localparam logic [2:0] REG_Y_COUNT = 3'd7;

   typedef struct packed {
      logic [0:0] command;
      logic [IndexW-1:0] voxel_index;
      logic signed [SampleW-1:0] voxel_value;
      logic signed [CoordW-1:0] point_x;
      logic signed [CoordW-1:0] point_y;
      logic signed [CoordW-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [CoordW-1:0] interpolated;
      logic out_of_range;
   } rsp_type;

endpackage

@@ hw/rtl/tgi_req_if.sv @@
`timescale 1ns / 1ps
interface tgi_req_if
   import tgi_pkg::*;
();
   logic valid;
   logic ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/tgi_rsp_if.sv @@
`timescale 1ns / 1ps
interface tgi_rsp_if
   import tgi_pkg::*;
();
   logic valid;
   logic ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/trilinear_grid_interpolator_core.sv @@
`timescale 1ns / 1ps
// Trilinear interpolator over a volume of signed 16-bit samples held in one on-chip memory.
// A write item stores one sample. A query item runs through one shared restoring divider,
// one quotient bit a cycle. Each axis runs through a setup step, a 48-bit division for the
// cell index, a check step, a 48-bit division for the fraction and a step to store it. The
// cell base is then formed in two steps. Each of the eight corners then runs through four
// steps: a memory read, a weight product, a sample product and a multiply-accumulate, the
// three products on one shared 34 by 34 multiplier. Rounding and hand-off follow. The result
// is held in an output register; the block keeps accepting items, and a following query
// waits in its last step until the earlier result is taken. Queries that fall outside the
// grid, whose cell starts at the last sample, or that meet a zero step or a count below two
// return zero with out_of_range set and finish early. No clearing pass is needed.
module trilinear_grid_interpolator_core
   import tgi_pkg::*;
#(
   parameter int MAX_X = 64,
   parameter int MAX_Y = 64,
   parameter int MAX_Z = 64
) (
   input logic clock,
   input logic reset,
   tgi_req_if.sink req,
   tgi_rsp_if.source rsp,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [CsrAddrW-1:0] csr_paddr,
   input logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);

   localparam int Depth = MAX_X * MAX_Y * MAX_Z;
   localparam int AddrW = $clog2(Depth);
   localparam int DivW = 48;
   localparam int DivCntW = 6;

   typedef enum logic [3:0] {
      S_IDLE, S_WRITE, S_DIV_INIT, S_DIV, S_FRAC, S_AXIS_DONE,
      S_BASE1, S_BASE2, S_READ, S_MUL1, S_MUL2, S_ACC, S_ROUND, S_OUT
   } state_type;

   state_type state_ff;
   logic signed [CoordW-1:0] x_origin_ff, y_origin_ff, z_origin_ff;
   logic [StepW-1:0] x_step_ff, y_step_ff, z_step_ff;
   logic [CountW-1:0] x_count_ff, y_count_ff;

   logic signed [SampleW-1:0] mem [Depth];
   logic signed [SampleW-1:0] rd_ff;

   req_type item_ff;
   logic [1:0] axis_ff;
   logic frac_pass_ff;
   logic [DivW-1:0] num_ff;
   logic [StepW:0] rem_ff;
   logic [DivW-1:0] quo_ff;
   logic [DivCntW-1:0] cnt_ff;
   logic neg_ff;
   logic [33:0] cell_ff [3];
   logic [FracW:0] frac_ff [3];
   logic oor_ff;
   logic [2:0] corner_ff;
   logic [31:0] base_ff;
   logic signed [33:0] prod_ff;
   logic signed [33:0] sw_ff;
   logic signed [63:0] acc_ff;
   rsp_type rsp_ff;
   logic rsp_valid_ff;

   logic [CountW-1:0] nx, ny;
   logic [StepW-1:0] step_cur;
   logic signed [CoordW-1:0] org_cur, pt_cur;
   logic signed [33:0] diff;
   logic [StepW+1:0] trial;
   logic [33:0] q_floor;
   logic [StepW-1:0] r_fix;
   logic [33:0] lim;
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] mul_p;
   logic [31:0] corner_addr;
   logic [FracW:0] wx, wy, wz;
   logic signed [63:0] rnd;

   always_comb begin
      nx = (32'(x_count_ff) > 32'(MAX_X)) ? CountW'(MAX_X) : x_count_ff;
      ny = (32'(y_count_ff) > 32'(MAX_Y)) ? CountW'(MAX_Y) : y_count_ff;
      case (axis_ff)
         2'd0: begin
            step_cur = x_step_ff; org_cur = x_origin_ff; pt_cur = item_ff.point_x;
            lim = 34'(nx) - 34'd2;
         end
         2'd1: begin
            step_cur = y_step_ff; org_cur = y_origin_ff; pt_cur = item_ff.point_y;
            lim = 34'(ny) - 34'd2;
         end
         default: begin
            step_cur = z_step_ff; org_cur = z_origin_ff; pt_cur = item_ff.point_z;
            lim = 34'(MAX_Z - 2);
         end
      endcase
      diff = 34'(pt_cur) - 34'(org_cur);
      trial = {rem_ff, num_ff[DivW-1]} - {1'b0, 1'b0, step_cur};
      // Floor correction for a negative difference with a nonzero remainder.
      if (neg_ff && rem_ff != '0) begin
         q_floor = ~quo_ff[33:0];
         r_fix = step_cur - rem_ff[StepW-1:0];
      end else begin
         q_floor = neg_ff ? (~quo_ff[33:0] + 34'd1) : quo_ff[33:0];
         r_fix = rem_ff[StepW-1:0];
      end
      wx = corner_ff[0] ? frac_ff[0] : (17'h10000 - frac_ff[0]);
      wy = corner_ff[1] ? frac_ff[1] : (17'h10000 - frac_ff[1]);
      wz = corner_ff[2] ? frac_ff[2] : (17'h10000 - frac_ff[2]);
      corner_addr = base_ff + 32'(corner_ff[0]) + (corner_ff[1] ? 32'(nx) : 32'd0)
         + (corner_ff[2] ? 32'(ny) * 32'(nx) : 32'd0);
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_BASE1: begin
            mul_a = signed'(cell_ff[2]); mul_b = signed'(34'(ny));
         end
         S_BASE2: begin
            mul_a = signed'(34'(base_ff)); mul_b = signed'(34'(nx));
         end
         S_MUL1: begin
            mul_a = signed'(34'(wx)); mul_b = signed'(34'(wy));
         end
         S_MUL2: begin
            mul_a = signed'(34'(rd_ff)); mul_b = signed'(34'(wz));
         end
         S_ACC: begin
            mul_a = prod_ff; mul_b = sw_ff;
         end
         default: begin
            mul_a = '0; mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
      rnd = acc_ff + 64'sh80000000;
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_WRITE && 32'(item_ff.voxel_index) < 32'(Depth)) begin
         mem[AddrW'(item_ff.voxel_index)] <= item_ff.voxel_value;
      end
      if (state_ff == S_READ) begin
         rd_ff <= (corner_addr < 32'(Depth)) ? mem[corner_addr[AddrW-1:0]] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         x_origin_ff <= '0; y_origin_ff <= '0; z_origin_ff <= '0;
         x_step_ff <= StepW'(65536); y_step_ff <= StepW'(65536); z_step_ff <= StepW'(65536);
         x_count_ff <= CountW'(64); y_count_ff <= CountW'(64);
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            case (csr_paddr[4:2])
               REG_X_ORIGIN: x_origin_ff <= csr_pwdata;
               REG_Y_ORIGIN: y_origin_ff <= csr_pwdata;
               REG_Z_ORIGIN: z_origin_ff <= csr_pwdata;
               REG_X_STEP: x_step_ff <= csr_pwdata[StepW-1:0];
               REG_Y_STEP: y_step_ff <= csr_pwdata[StepW-1:0];
               REG_Z_STEP: z_step_ff <= csr_pwdata[StepW-1:0];
               REG_X_COUNT: x_count_ff <= csr_pwdata[CountW-1:0];
               REG_Y_COUNT: y_count_ff <= csr_pwdata[CountW-1:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp.ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  item_ff <= req.payload;
                  axis_ff <= 2'd0;
                  oor_ff <= 1'b0;
                  state_ff <= (req.payload.command == CMD_QUERY) ? S_DIV_INIT : S_WRITE;
               end
            end
            S_WRITE: state_ff <= S_IDLE;
            S_DIV_INIT: begin
               if (step_cur == '0 || lim[33]) begin
                  oor_ff <= 1'b1;
                  state_ff <= S_OUT;
               end else begin
                  neg_ff <= diff[33];
                  num_ff <= DivW'(diff[33] ? -diff : diff);
                  rem_ff <= '0; quo_ff <= '0; cnt_ff <= '0;
                  frac_pass_ff <= 1'b0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (!trial[StepW+1]) begin
                  rem_ff <= trial[StepW:0];
               end else begin
                  rem_ff <= {rem_ff[StepW-1:0], num_ff[DivW-1]};
               end
               quo_ff <= {quo_ff[DivW-2:0], ~trial[StepW+1]};
               num_ff <= {num_ff[DivW-2:0], 1'b0};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == DivCntW'(DivW-1)) begin
                  state_ff <= frac_pass_ff ? S_AXIS_DONE : S_FRAC;
               end
            end
            S_FRAC: begin
               if (signed'(q_floor) < 0 || signed'(q_floor) > signed'(lim)) begin
                  oor_ff <= 1'b1;
                  state_ff <= S_OUT;
               end else begin
                  cell_ff[axis_ff] <= q_floor;
                  neg_ff <= 1'b0;
                  num_ff <= {1'b0, r_fix, 16'd0};
                  rem_ff <= '0; quo_ff <= '0; cnt_ff <= '0;
                  frac_pass_ff <= 1'b1;
                  state_ff <= S_DIV;
               end
            end
            S_AXIS_DONE: begin
               frac_ff[axis_ff] <= {1'b0, quo_ff[FracW-1:0]};
               if (axis_ff == 2'd2) begin
                  state_ff <= S_BASE1;
               end else begin
                  axis_ff <= axis_ff + 2'd1;
                  state_ff <= S_DIV_INIT;
               end
            end
            S_BASE1: begin
               base_ff <= 32'(mul_p) + 32'(cell_ff[1]);
               state_ff <= S_BASE2;
            end
            S_BASE2: begin
               base_ff <= 32'(mul_p) + 32'(cell_ff[0]);
               corner_ff <= '0;
               acc_ff <= '0;
               state_ff <= S_READ;
            end
            S_READ: state_ff <= S_MUL1;
            S_MUL1: begin
               prod_ff <= mul_p[33:0];
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               sw_ff <= mul_p[33:0];
               state_ff <= S_ACC;
            end
            S_ACC: begin
               acc_ff <= acc_ff + mul_p[63:0];
               corner_ff <= corner_ff + 3'd1;
               state_ff <= (corner_ff == 3'd7) ? S_ROUND : S_READ;
            end
            S_ROUND: state_ff <= S_OUT;
            S_OUT: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_ff.out_of_range <= oor_ff;
                  rsp_ff.interpolated <= oor_ff ? '0 : rnd[63:32];
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req.ready = (state_ff == S_IDLE) && !reset;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_paddr[4:2])
         REG_X_ORIGIN: csr_prdata = x_origin_ff;
         REG_Y_ORIGIN: csr_prdata = y_origin_ff;
         REG_Z_ORIGIN: csr_prdata = z_origin_ff;
         REG_X_STEP: csr_prdata = 32'(x_step_ff);
         REG_Y_STEP: csr_prdata = 32'(y_step_ff);
         REG_Z_STEP: csr_prdata = 32'(z_step_ff);
         REG_X_COUNT: csr_prdata = 32'(x_count_ff);
         REG_Y_COUNT: csr_prdata = 32'(y_count_ff);
         default: csr_prdata = '0;
      endcase
   end

`ifndef SYNTH
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.out_of_range |-> rsp.payload.interpolated == '0)
      else $error("out of range result not zero");
   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WRITE && !rsp_valid_ff |=> !rsp_valid_ff)
      else $error("write produced a result");
`endif

endmodule
